@@ hdl/cet_pkg.sv @@
// Shared types, constants and arithmetic step functions for the capsule endpoint pipeline.
package cet_pkg;

  // Arithmetic sizes
  localparam int unsigned RootBits = 32;   // integer square root of a 64-bit radicand
  localparam int unsigned QuoBits  = 31;   // normalized entry, up to 1.0 in Q1.30

  // Near-zero axis threshold, 1e-6 in Q.46
  localparam logic [31:0] AxisEpsQ46 = 32'd70368744;
  localparam logic [30:0] OneQ30     = 31'h4000_0000;
  localparam logic [30:0] RadMax     = 31'h7FFF_FFFF;

  // Register reset values
  localparam logic [31:0] AxisYReset      = 32'h0001_0000;
  localparam logic [30:0] BaseRadiusReset = 31'h0000_8000;
  localparam logic [30:0] HalfLengthReset = 31'h0001_0000;

  // Register indexes
  typedef enum logic [2:0] {
    RegOffsetX    = 3'd0,
    RegOffsetY    = 3'd1,
    RegOffsetZ    = 3'd2,
    RegAxisX      = 3'd3,
    RegAxisY      = 3'd4,
    RegAxisZ      = 3'd5,
    RegBaseRadius = 3'd6,
    RegHalfLength = 3'd7
  } cfg_reg_e;

  // Square root recurrence state
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_acc_t;

  // Restoring division state
  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] quo;
  } div_acc_t;

  // Sideband through the row-scale square root
  typedef struct packed {
    logic [8:0][31:0] mag;
    logic [8:0]       neg;
    logic [2:0][31:0] trans;
  } sqa_side_t;

  // Sideband through the row normalization divider
  typedef struct packed {
    logic [8:0]       neg;
    logic [2:0][31:0] scale;
    logic [2:0][31:0] trans;
  } dva_side_t;

  // Sideband through the axis length square root
  typedef struct packed {
    logic [2:0][30:0] vmag;
    logic [2:0]       neg;
    logic             kzero;
    logic [62:0]      half_ext;
    logic [2:0][31:0] trans;
    logic [30:0]      radius;
  } sqb_side_t;

  // Sideband through the axis normalization divider
  typedef struct packed {
    logic             near_zero;
    logic [2:0]       neg;
    logic [62:0]      half_ext;
    logic [2:0][31:0] trans;
    logic [30:0]      radius;
  } dvb_side_t;

  // One result
  typedef struct packed {
    logic [2:0][31:0] pt_start;
    logic [2:0][31:0] pt_end;
    logic [30:0]      radius;
  } out_t;

  // One digit of the square root recurrence
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [34:0] cur;
    logic [34:0] trial;
    sqrt_acc_t   res;
    cur   = {acc.rem[32:0], pair};
    trial = {1'b0, acc.root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {acc.root[30:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {acc.root[30:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit of restoring division
  function automatic div_acc_t div_step(div_acc_t acc, logic bit_in, logic [31:0] dvs);
    logic [32:0] cur;
    logic [32:0] diff;
    div_acc_t    res;
    cur  = {acc.rem, bit_in};
    diff = cur - {1'b0, dvs};
    if (cur >= {1'b0, dvs}) begin
      res.rem = diff[31:0];
      res.quo = {acc.quo[29:0], 1'b1};
    end else begin
      res.rem = cur[31:0];
      res.quo = {acc.quo[29:0], 1'b0};
    end
    return res;
  endfunction

  // Right shift that brings a 63-bit magnitude below 2^31
  function automatic logic [5:0] lead_shift(logic [62:0] x);
    logic [5:0] k;
    k = '0;
    for (int i = 31; i < 63; i++) begin
      if (x[i]) begin
        k = 6'(i - 30);
      end
    end
    return k;
  endfunction

  // Saturate a 50-bit signed value to 32 bits
  function automatic logic [31:0] sat32(logic [49:0] x);
    logic [31:0] r;
    if (!x[49] && (|x[48:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (x[49] && !(&x[48:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/capsule_endpoints_from_transform.sv @@
// Capsule endpoint and radius pipeline, top level.
//
// Use: present an object's world matrix (three scaled basis rows and a translation,
// signed Q16.16) on the input channel with in_valid_i; it is taken when in_ready_o
// is high. Each request yields one result on the output channel: the two capsule
// endpoints and the scaled radius, all saturated Q16.16.
// The path holds 141 register stages. Throughput is one request per cycle while in_ready_o
// is high; the depth is set by the two bit-serial square root pipelines (32 stages each)
// and the two restoring divider pipelines (31 stages each), plus an input register,
// thirteen stages of multiply, add, shift and saturate, and the output register.
// Results leave through an output register backed by one skid entry. When the receiver
// holds out_ready_i low, the pipeline keeps running until the skid entry fills; then
// in_ready_o drops and every stage holds its data, so nothing is lost or repeated.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and must
// be made only while no request is in flight.
// Reset clears all valid bits and loads the registers with offset 0, axis (0,1,0),
// radius 0.5 and half length 1.0.
module capsule_endpoints_from_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] row0_x_i,
  input  logic [31:0] row0_y_i,
  input  logic [31:0] row0_z_i,
  input  logic [31:0] row1_x_i,
  input  logic [31:0] row1_y_i,
  input  logic [31:0] row1_z_i,
  input  logic [31:0] row2_x_i,
  input  logic [31:0] row2_y_i,
  input  logic [31:0] row2_z_i,
  input  logic [31:0] trans_x_i,
  input  logic [31:0] trans_y_i,
  input  logic [31:0] trans_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] start_x_o,
  output logic [31:0] start_y_o,
  output logic [31:0] start_z_o,
  output logic [31:0] end_x_o,
  output logic [31:0] end_y_o,
  output logic [31:0] end_z_o,
  output logic [30:0] scaled_radius_o
);
  import cet_pkg::*;

  // Configuration registers
  logic [2:0][31:0] offset_q;
  logic [2:0][31:0] axis_q;
  logic [30:0]      base_radius_q;
  logic [30:0]      half_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      axis_q        <= {32'h0, AxisYReset, 32'h0};
      base_radius_q <= BaseRadiusReset;
      half_length_q <= HalfLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegOffsetX:    offset_q[0]   <= cfg_wdata_i;
        RegOffsetY:    offset_q[1]   <= cfg_wdata_i;
        RegOffsetZ:    offset_q[2]   <= cfg_wdata_i;
        RegAxisX:      axis_q[0]     <= cfg_wdata_i;
        RegAxisY:      axis_q[1]     <= cfg_wdata_i;
        RegAxisZ:      axis_q[2]     <= cfg_wdata_i;
        RegBaseRadius: base_radius_q <= cfg_wdata_i[30:0];
        RegHalfLength: half_length_q <= cfg_wdata_i[30:0];
        default:       ;
      endcase
    end
  end

  logic en;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- front stages
  logic             v0_q, v1_q, v2_q;
  logic [8:0][31:0] m0_q;
  logic [2:0][31:0] t0_q, t1_q, t2_q;
  logic [8:0][31:0] mag1_d, mag1_q, mag2_q;
  logic [8:0]       neg1_q, neg2_q;
  logic [8:0][63:0] sq1_d, sq1_q;
  logic [2:0][63:0] sum2_d, sum2_q;

  // Element magnitudes and squares
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      mag1_d[e] = m0_q[e][31] ? 32'(32'd0 - m0_q[e]) : m0_q[e];
      sq1_d[e]  = {32'd0, mag1_d[e]} * {32'd0, mag1_d[e]};
    end
    for (int r = 0; r < 3; r++) begin
      sum2_d[r] = sq1_q[3*r] + sq1_q[3*r+1] + sq1_q[3*r+2];
    end
  end

  // ---------------------------------------------------------------- row scale and normalize
  sqa_side_t sqa_in, sqa_out;
  logic      sqa_vld;
  logic [2:0][31:0] scale_a;
  dva_side_t dva_in, dva_out;
  logic      dva_vld;
  logic [8:0][31:0] dva_dvs;
  logic [8:0][30:0] nq;

  assign sqa_in.mag   = mag2_q;
  assign sqa_in.neg   = neg2_q;
  assign sqa_in.trans = t2_q;

  cet_isqrt_pipe #(
    .Lanes (3),
    .SideW ($bits(sqa_side_t))
  ) u_sqrt_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (sum2_q),
    .side_i  (sqa_in),
    .valid_o (sqa_vld),
    .root_o  (scale_a),
    .side_o  (sqa_out)
  );

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      dva_dvs[e] = scale_a[e/3];
    end
  end

  assign dva_in.neg   = sqa_out.neg;
  assign dva_in.scale = scale_a;
  assign dva_in.trans = sqa_out.trans;

  cet_div_pipe #(
    .Lanes (9),
    .SideW ($bits(dva_side_t))
  ) u_div_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqa_vld),
    .mag_i   (sqa_out.mag),
    .dvs_i   (dva_dvs),
    .side_i  (dva_in),
    .valid_o (dva_vld),
    .quo_o   (nq),
    .side_o  (dva_out)
  );

  // ---------------------------------------------------------------- world axis
  logic             v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic [8:0][31:0] n3_d, n3_q;
  logic [62:0]      he3_q, he4_q, he5_q, he6_q, he7_q, he8_q, he9_q, he10_q;
  logic [32:0]      ssum3_q;
  logic [2:0][31:0] t3_q, t4_q, t5_q, t6_q, t7_q, t8_q, t9_q, t10_q;
  logic [8:0][63:0] prod4_d, prod4_q;
  logic [63:0]      rprod4_q;
  logic [2:0][63:0] w5_d, w5_q;
  logic [30:0]      rad5_d, rad5_q, rad6_q, rad7_q, rad8_q, rad9_q, rad10_q;
  logic [46:0]      rshift;
  logic [2:0][62:0] vm6_d, vm6_q, vm7_q;
  logic [2:0]       neg6_q, neg7_q, neg8_q, neg9_q, neg10_q;
  logic [5:0]       k7_q;
  logic [2:0][30:0] vs8_d, vs8_q, vs9_q, vs10_q;
  logic             kz8_q, kz9_q, kz10_q;
  logic [2:0][61:0] vsq9_d, vsq9_q;
  logic [63:0]      rad10_d;
  logic [63:0]      len_rad_q;

  always_comb begin
    // Normalized rows, zero rows stay zero
    for (int e = 0; e < 9; e++) begin
      if (dva_out.scale[e/3] == 32'd0) begin
        n3_d[e] = '0;
      end else if (dva_out.neg[e]) begin
        n3_d[e] = 32'(32'd0 - {1'b0, nq[e]});
      end else begin
        n3_d[e] = {1'b0, nq[e]};
      end
    end
    // Axis times normalized rows, element e = row * 3 + column
    for (int e = 0; e < 9; e++) begin
      prod4_d[e] = 64'($signed(axis_q[e/3]) * $signed(n3_q[e]));
    end
    for (int j = 0; j < 3; j++) begin
      w5_d[j] = prod4_q[j] + prod4_q[3+j] + prod4_q[6+j];
    end
    // Radius, saturated
    rshift = rprod4_q[63:17];
    rad5_d = (rshift > {16'd0, RadMax}) ? RadMax : rshift[30:0];
    // Magnitudes of the world axis
    for (int j = 0; j < 3; j++) begin
      vm6_d[j] = w5_q[j][63] ? 63'(64'd0 - w5_q[j]) : w5_q[j][62:0];
    end
    // Bring all components below 2^31
    for (int j = 0; j < 3; j++) begin
      vs8_d[j]  = 31'(vm7_q[j] >> k7_q);
      vsq9_d[j] = {31'd0, vs8_q[j]} * {31'd0, vs8_q[j]};
    end
    rad10_d = {2'b00, vsq9_q[0]} + {2'b00, vsq9_q[1]} + {2'b00, vsq9_q[2]};
  end

  // Front and mid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v0_q  <= in_valid_i;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= dva_vld;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  // Front and mid stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q     <= {row2_z_i, row2_y_i, row2_x_i, row1_z_i, row1_y_i, row1_x_i,
                   row0_z_i, row0_y_i, row0_x_i};
      t0_q     <= {trans_z_i, trans_y_i, trans_x_i};
      mag1_q   <= mag1_d;
      sq1_q    <= sq1_d;
      for (int e = 0; e < 9; e++) begin
        neg1_q[e] <= m0_q[e][31];
      end
      t1_q     <= t0_q;
      sum2_q   <= sum2_d;
      mag2_q   <= mag1_q;
      neg2_q   <= neg1_q;
      t2_q     <= t1_q;
      // after row normalization
      n3_q     <= n3_d;
      he3_q    <= {32'd0, half_length_q} * {31'd0, dva_out.scale[1]};
      ssum3_q  <= {1'b0, dva_out.scale[0]} + {1'b0, dva_out.scale[2]};
      t3_q     <= dva_out.trans;
      prod4_q  <= prod4_d;
      rprod4_q <= {33'd0, base_radius_q} * {31'd0, ssum3_q};
      he4_q    <= he3_q;
      t4_q     <= t3_q;
      w5_q     <= w5_d;
      rad5_q   <= rad5_d;
      he5_q    <= he4_q;
      t5_q     <= t4_q;
      vm6_q    <= vm6_d;
      for (int j = 0; j < 3; j++) begin
        neg6_q[j] <= w5_q[j][63];
      end
      rad6_q   <= rad5_q;
      he6_q    <= he5_q;
      t6_q     <= t5_q;
      k7_q     <= lead_shift(vm6_q[0] | vm6_q[1] | vm6_q[2]);
      vm7_q    <= vm6_q;
      neg7_q   <= neg6_q;
      rad7_q   <= rad6_q;
      he7_q    <= he6_q;
      t7_q     <= t6_q;
      vs8_q    <= vs8_d;
      kz8_q    <= (k7_q == 6'd0);
      neg8_q   <= neg7_q;
      rad8_q   <= rad7_q;
      he8_q    <= he7_q;
      t8_q     <= t7_q;
      vsq9_q   <= vsq9_d;
      vs9_q    <= vs8_q;
      kz9_q    <= kz8_q;
      neg9_q   <= neg8_q;
      rad9_q   <= rad8_q;
      he9_q    <= he8_q;
      t9_q     <= t8_q;
      len_rad_q <= rad10_d;
      vs10_q   <= vs9_q;
      kz10_q   <= kz9_q;
      neg10_q  <= neg9_q;
      rad10_q  <= rad9_q;
      he10_q   <= he9_q;
      t10_q    <= t9_q;
    end
  end

  // ---------------------------------------------------------------- axis length and normalize
  sqb_side_t sqb_in, sqb_out;
  logic      sqb_vld;
  logic [0:0][31:0] len_b;
  dvb_side_t dvb_in, dvb_out;
  logic      dvb_vld;
  logic [2:0][31:0] dvb_mag, dvb_dvs;
  logic [2:0][30:0] uq;

  assign sqb_in.vmag     = vs10_q;
  assign sqb_in.neg      = neg10_q;
  assign sqb_in.kzero    = kz10_q;
  assign sqb_in.half_ext = he10_q;
  assign sqb_in.trans    = t10_q;
  assign sqb_in.radius   = rad10_q;

  cet_isqrt_pipe #(
    .Lanes (1),
    .SideW ($bits(sqb_side_t))
  ) u_sqrt_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v10_q),
    .rad_i   (len_rad_q),
    .side_i  (sqb_in),
    .valid_o (sqb_vld),
    .root_o  (len_b),
    .side_o  (sqb_out)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dvb_mag[j] = {1'b0, sqb_out.vmag[j]};
      dvb_dvs[j] = len_b[0];
    end
  end

  assign dvb_in.near_zero = sqb_out.kzero && (len_b[0] <= AxisEpsQ46);
  assign dvb_in.neg       = sqb_out.neg;
  assign dvb_in.half_ext  = sqb_out.half_ext;
  assign dvb_in.trans     = sqb_out.trans;
  assign dvb_in.radius    = sqb_out.radius;

  cet_div_pipe #(
    .Lanes (3),
    .SideW ($bits(dvb_side_t))
  ) u_div_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqb_vld),
    .mag_i   (dvb_mag),
    .dvs_i   (dvb_dvs),
    .side_i  (dvb_in),
    .valid_o (dvb_vld),
    .quo_o   (uq),
    .side_o  (dvb_out)
  );

  // ---------------------------------------------------------------- endpoints
  logic             v12_q, v13_q, v14_q;
  logic [2:0][30:0] umag12_d, umag12_q;
  logic [2:0]       uneg12_q, uneg13_q, uneg14_q;
  logic [2:0][32:0] c12_d, c12_q, c13_q, c14_q;
  logic [62:0]      he12_q;
  logic [30:0]      rad12_q, rad13_q, rad14_q;
  logic [2:0][61:0] pa13_q;
  logic [2:0][62:0] pb13_q;
  logic [2:0][93:0] full14;
  logic [2:0][47:0] d14_d, d14_q;
  logic [2:0][49:0] dd, c50;
  out_t             res;

  always_comb begin
    // Unit axis, with the (0,1,0) fallback for a near-zero axis
    for (int j = 0; j < 3; j++) begin
      if (dvb_out.near_zero) begin
        umag12_d[j] = (j == 1) ? OneQ30 : '0;
      end else begin
        umag12_d[j] = uq[j];
      end
      c12_d[j] = {dvb_out.trans[j][31], dvb_out.trans[j]} + {offset_q[j][31], offset_q[j]};
    end
    // Axis times half extent, scaled down by 2^46
    for (int j = 0; j < 3; j++) begin
      full14[j] = {pa13_q[j], 32'd0} + {31'd0, pb13_q[j]};
      d14_d[j]  = full14[j][93:46];
    end
    // Center -/+ offset along the axis, saturated
    for (int j = 0; j < 3; j++) begin
      c50[j] = {{17{c14_q[j][32]}}, c14_q[j]};
      dd[j]  = uneg14_q[j] ? 50'(50'd0 - {2'b00, d14_q[j]}) : {2'b00, d14_q[j]};
      res.pt_start[j] = sat32(c50[j] - dd[j]);
      res.pt_end[j]   = sat32(c50[j] + dd[j]);
    end
    res.radius = rad14_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
      v13_q <= 1'b0;
      v14_q <= 1'b0;
    end else if (en) begin
      v12_q <= dvb_vld;
      v13_q <= v12_q;
      v14_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      umag12_q <= umag12_d;
      for (int j = 0; j < 3; j++) begin
        uneg12_q[j] <= !dvb_out.near_zero && dvb_out.neg[j];
        pa13_q[j]   <= {31'd0, umag12_q[j]} * {31'd0, he12_q[62:32]};
        pb13_q[j]   <= {32'd0, umag12_q[j]} * {31'd0, he12_q[31:0]};
      end
      c12_q    <= c12_d;
      he12_q   <= dvb_out.half_ext;
      rad12_q  <= dvb_out.radius;
      uneg13_q <= uneg12_q;
      c13_q    <= c12_q;
      rad13_q  <= rad12_q;
      d14_q    <= d14_d;
      uneg14_q <= uneg13_q;
      c14_q    <= c13_q;
      rad14_q  <= rad13_q;
    end
  end

  // ---------------------------------------------------------------- output
  out_t out_data;

  cet_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v14_q),
    .data_i  (res),
    .ready_o (en),
    .valid_o (out_valid_o),
    .data_o  (out_data),
    .ready_i (out_ready_i)
  );

  assign start_x_o       = out_data.pt_start[0];
  assign start_y_o       = out_data.pt_start[1];
  assign start_z_o       = out_data.pt_start[2];
  assign end_x_o         = out_data.pt_end[0];
  assign end_y_o         = out_data.pt_end[1];
  assign end_z_o         = out_data.pt_end[2];
  assign scaled_radius_o = out_data.radius;

endmodule

@@ hdl/cet_isqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, several lanes in parallel.
module cet_isqrt_pipe #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [Lanes-1:0][63:0] rad_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [Lanes-1:0][31:0] root_o,
  output logic [SideW-1:0]       side_o
);
  import cet_pkg::*;

  logic [RootBits-1:0]                   vld_q;
  sqrt_acc_t [RootBits-1:0][Lanes-1:0]   acc_q, acc_d;
  logic [RootBits-1:0][Lanes-1:0][63:0]  rad_q, rad_d;
  logic [RootBits-1:0][SideW-1:0]        side_q;

  // One recurrence digit per stage, radicand consumed two bits at a time
  for (genvar gs = 0; gs < RootBits; gs++) begin : g_stage
    for (genvar gl = 0; gl < Lanes; gl++) begin : g_lane
      if (gs == 0) begin : g_first
        assign acc_d[gs][gl] = sqrt_step(sqrt_acc_t'('0), rad_i[gl][63:62]);
        assign rad_d[gs][gl] = {rad_i[gl][61:0], 2'b00};
      end else begin : g_next
        assign acc_d[gs][gl] = sqrt_step(acc_q[gs-1][gl], rad_q[gs-1][gl][63:62]);
        assign rad_d[gs][gl] = {rad_q[gs-1][gl][61:0], 2'b00};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootBits-2:0], valid_i};
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q     <= acc_d;
      rad_q     <= rad_d;
      side_q[0] <= side_i;
      for (int s = 1; s < RootBits; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      root_o[l] = acc_q[RootBits-1][l].root;
    end
  end

  assign valid_o = vld_q[RootBits-1];
  assign side_o  = side_q[RootBits-1];

endmodule

@@ hdl/cet_div_pipe.sv @@
// Pipelined restoring divider: floor(mag * 2^30 / dvs) for mag <= dvs, one quotient bit per stage.
module cet_div_pipe #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [Lanes-1:0][31:0] mag_i,
  input  logic [Lanes-1:0][31:0] dvs_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [Lanes-1:0][30:0] quo_o,
  output logic [SideW-1:0]       side_o
);
  import cet_pkg::*;

  logic [QuoBits-1:0]                   vld_q;
  div_acc_t [QuoBits-1:0][Lanes-1:0]    acc_q, acc_d;
  logic [QuoBits-1:0][Lanes-1:0][31:0]  dvs_q;
  logic [QuoBits-1:0][SideW-1:0]        side_q;

  // Upper dividend bits are mag >> 1 (below the divisor); the first step brings in mag[0],
  // the rest bring in zeros
  for (genvar gs = 0; gs < QuoBits; gs++) begin : g_stage
    for (genvar gl = 0; gl < Lanes; gl++) begin : g_lane
      if (gs == 0) begin : g_first
        assign acc_d[gs][gl] = div_step(div_acc_t'{rem: {1'b0, mag_i[gl][31:1]}, quo: '0},
                                        mag_i[gl][0], dvs_i[gl]);
      end else begin : g_next
        assign acc_d[gs][gl] = div_step(acc_q[gs-1][gl], 1'b0, dvs_q[gs-1][gl]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoBits-2:0], valid_i};
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q     <= acc_d;
      dvs_q[0]  <= dvs_i;
      side_q[0] <= side_i;
      for (int s = 1; s < QuoBits; s++) begin
        dvs_q[s]  <= dvs_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      quo_o[l] = acc_q[QuoBits-1][l].quo;
    end
  end

  assign valid_o = vld_q[QuoBits-1];
  assign side_o  = side_q[QuoBits-1];

endmodule

@@ hdl/cet_out_buf.sv @@
// Output register with one skid entry; the pipeline stalls only when the skid entry is full.
module cet_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cet_pkg::out_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cet_pkg::out_t data_o,
  input  logic          ready_i
);
  import cet_pkg::*;

  logic out_vld_q, skid_vld_q;
  out_t out_q, skid_q;
  logic to_skid, to_out, skid_drain;

  assign ready_o    = !skid_vld_q;
  assign skid_drain = skid_vld_q && ready_i;
  assign to_skid    = !skid_vld_q && valid_i && out_vld_q && !ready_i;
  assign to_out     = !skid_vld_q && valid_i && !(out_vld_q && !ready_i);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_drain) begin
        skid_vld_q <= 1'b0;
      end else if (to_skid) begin
        skid_vld_q <= 1'b1;
      end
      if (to_out) begin
        out_vld_q <= 1'b1;
      end else if (!skid_vld_q && ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Data
  always_ff @(posedge clk_i) begin
    if (skid_drain) begin
      out_q <= skid_q;
    end else if (to_out) begin
      out_q <= data_i;
    end
    if (to_skid) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

@@ tb/sv/capsule_checker.sv @@
// Checker: watches the request and result channels, predicts capsule endpoints and compares.
module capsule_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [11:0][31:0] mat_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0][31:0] res_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cet_pkg::*;

  typedef logic [6:0][31:0] capsule_t;

  // Shadow copy of the configuration registers
  logic signed [63:0] ofs [3];
  logic signed [63:0] ax [3];
  logic [63:0] base_rad, half_len;
  capsule_t expected_caps[$];

  assign pending_o = expected_caps.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Capsule prediction for one world matrix
  function automatic capsule_t predict_capsule(logic [11:0][31:0] m);
    logic signed [63:0] e [9];
    logic signed [63:0] nrm [9];
    logic signed [63:0] w [3];
    logic signed [63:0] u [3];
    logic [63:0] sc [3];
    logic [63:0] v [3];
    logic [63:0] sum, len, q, dm;
    logic [127:0] h, rad;
    logic signed [127:0] c, d;
    int sh;
    capsule_t r;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        e[i*3+j] = 64'(signed'(m[i*3+j]));
        sum += magn(e[i*3+j]) * magn(e[i*3+j]);
      end
      sc[i] = int_sqrt(sum);
      for (int j = 0; j < 3; j++) begin
        if (sc[i] == 0) begin
          nrm[i*3+j] = 0;
        end else begin
          q = (magn(e[i*3+j]) << 30) / sc[i];
          nrm[i*3+j] = e[i*3+j][63] ? -q : q;
        end
      end
    end
    for (int j = 0; j < 3; j++) begin
      w[j] = ax[0]*nrm[j] + ax[1]*nrm[3+j] + ax[2]*nrm[6+j];
      v[j] = magn(w[j]);
    end
    sh = 0;
    while (v[0] >= 64'h8000_0000 || v[1] >= 64'h8000_0000 || v[2] >= 64'h8000_0000) begin
      for (int j = 0; j < 3; j++) v[j] = v[j] >> 1;
      sh++;
    end
    len = int_sqrt(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]);
    // Near-zero world axis falls back to +Y
    if (sh == 0 && len <= 64'(AxisEpsQ46)) begin
      u[0] = 0;
      u[1] = 64'(OneQ30);
      u[2] = 0;
    end else begin
      for (int j = 0; j < 3; j++) begin
        q = (v[j] << 30) / len;
        u[j] = w[j][63] ? -q : q;
      end
    end
    h = 128'(half_len) * 128'(sc[1]);
    for (int j = 0; j < 3; j++) begin
      c = 128'(signed'(m[9+j])) + 128'(ofs[j]);
      dm = 64'((128'(magn(u[j])) * h) >> 46);
      d = u[j][63] ? -128'(dm) : 128'(dm);
      r[j] = clamp32(c - d);
      r[3+j] = clamp32(c + d);
    end
    rad = (128'(base_rad) * (128'(sc[0]) + 128'(sc[2]))) >> 17;
    r[6] = (rad > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : rad[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    capsule_t got, exp_c;
    if (!rst_ni) begin
      foreach (ofs[i]) ofs[i] = 0;
      ax[0] = 0;
      ax[1] = 64'(AxisYReset);
      ax[2] = 0;
      base_rad = 64'(BaseRadiusReset);
      half_len = 64'(HalfLengthReset);
      errors_o = 0;
      expected_caps.delete();
    end else begin
      // Register write
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegOffsetX:    ofs[0] = 64'(signed'(cfg_wdata_i));
          RegOffsetY:    ofs[1] = 64'(signed'(cfg_wdata_i));
          RegOffsetZ:    ofs[2] = 64'(signed'(cfg_wdata_i));
          RegAxisX:      ax[0] = 64'(signed'(cfg_wdata_i));
          RegAxisY:      ax[1] = 64'(signed'(cfg_wdata_i));
          RegAxisZ:      ax[2] = 64'(signed'(cfg_wdata_i));
          RegBaseRadius: base_rad = 64'(cfg_wdata_i[30:0]);
          RegHalfLength: half_len = 64'(cfg_wdata_i[30:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_caps.push_back(predict_capsule(mat_i));
      // Result compare
      if (out_valid_i && out_ready_i) begin
        got = res_i;
        got[6][31] = 1'b0;
        if (expected_caps.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          exp_c = expected_caps.pop_front();
          for (int f = 0; f < 7; f++) begin
            if (got[f] !== exp_c[f]) begin
              $error("%s mismatch: expected %h actual %h",
                     f == 0 ? "start_x" : f == 1 ? "start_y" : f == 2 ? "start_z" :
                     f == 3 ? "end_x" : f == 4 ? "end_y" : f == 5 ? "end_z" :
                     "scaled_radius", exp_c[f], got[f]);
              errors_o++;
            end
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the capsule endpoint pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cet_pkg::*;

  localparam int Latency = 141;
  localparam int WatchLimit = 5000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0, out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic [11:0][31:0] mat = '0;
  logic [5:0][31:0] res;
  logic [30:0] scaled_radius;
  int errors, pending, idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  capsule_endpoints_from_transform uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .row0_x_i(mat[0]), .row0_y_i(mat[1]), .row0_z_i(mat[2]),
    .row1_x_i(mat[3]), .row1_y_i(mat[4]), .row1_z_i(mat[5]),
    .row2_x_i(mat[6]), .row2_y_i(mat[7]), .row2_z_i(mat[8]),
    .trans_x_i(mat[9]), .trans_y_i(mat[10]), .trans_z_i(mat[11]),
    .out_valid_o, .out_ready_i,
    .start_x_o(res[0]), .start_y_o(res[1]), .start_z_o(res[2]),
    .end_x_o(res[3]), .end_y_o(res[4]), .end_z_o(res[5]),
    .scaled_radius_o(scaled_radius)
  );

  capsule_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mat_i(mat),
    .out_valid_i(out_valid_o), .out_ready_i, .res_i({1'b0, scaled_radius, res}),
    .errors_o(errors), .pending_o(pending)
  );

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      out_ready_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop the request and wait until every result has come back
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drive one request, holding valid until it is taken; returns at the accepting edge
  task automatic send_matrix(logic [11:0][31:0] m, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mat <= m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return $urandom_range(0, 3);
      default: return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic logic [11:0][31:0] rnd_matrix();
    logic [11:0][31:0] m;
    foreach (m[i]) m[i] = rnd_val();
    // Sometimes blank a row
    if ($urandom_range(0, 7) == 0) begin
      int r;
      r = $urandom_range(0, 2);
      m[r*3] = 0; m[r*3+1] = 0; m[r*3+2] = 0;
    end
    return m;
  endfunction

  task automatic random_config(int mode);
    logic [31:0] vals [8];
    foreach (vals[i]) vals[i] = (mode == 0) ? rnd_val() :
                               (mode == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (mode == 2) begin
      vals[RegBaseRadius] = 0;
      vals[RegHalfLength] = 0;
    end
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_e'(i), vals[i]);
  endtask

  initial begin
    logic [11:0][31:0] m;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity, zero rows, extremes, reset config
    m = '0;
    m[0] = 32'h0001_0000; m[4] = 32'h0001_0000; m[8] = 32'h0001_0000;
    send_matrix(m, 1'b0);
    send_matrix('0, 1'b0);
    for (int i = 0; i < 12; i++) m[i] = 32'h7FFF_FFFF;
    send_matrix(m, 1'b1);
    for (int i = 0; i < 12; i++) m[i] = 32'h8000_0000;
    send_matrix(m, 1'b1);
    m = '0; m[4] = 32'h0002_0000; m[9] = 32'h7FFF_FFFF;
    send_matrix(m, 1'b0);
    drain_pipe();

    // Axis collapsing toward zero: near-zero fallback
    write_reg(RegAxisY, 32'd1);
    m = '0; m[0] = 32'h0001_0000; m[4] = 32'h0001_0000; m[8] = 32'h0001_0000;
    send_matrix(m, 1'b0);
    drain_pipe();
    write_reg(RegAxisY, 32'd0);
    send_matrix(m, 1'b0);
    send_matrix(rnd_matrix(), 1'b0);
    drain_pipe();
    random_config(1);
    send_matrix(m, 1'b0);
    for (int i = 0; i < 12; i++) m[i] = 32'h7FFF_FFFF;
    send_matrix(m, 1'b0);
    drain_pipe();
    random_config(2);
    send_matrix(m, 1'b0);
    send_matrix(rnd_matrix(), 1'b0);
    drain_pipe();

    // Random phases, each under a new configuration
    for (int ph = 0; ph < 10; ph++) begin
      random_config(0);
      if (ph % 3 == 0) write_reg(RegAxisX, 32'd0);
      for (int n = 0; n < 100; n++) begin
        send_matrix(rnd_matrix(), ($urandom_range(0, 4) == 0));
        // Sender holds off until the pipeline is empty
        if (n == 50) drain_pipe();
      end
      drain_pipe();
    end

    drain_pipe();
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/cet_pkg.sv
hdl/cet_isqrt_pipe.sv
hdl/cet_div_pipe.sv
hdl/cet_out_buf.sv
hdl/capsule_endpoints_from_transform.sv
tb/sv/capsule_checker.sv
tb/sv/testbench.sv
